// ----- design/stk_pkg.sv -----
// ----------------------------------------------------------------------------
// stk_pkg
// Shared types, character codes and helpers for the shell token scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package stk_pkg;

  localparam int unsigned MaxRes   = 4;
  localparam int unsigned ResIdxW  = $clog2(MaxRes);
  localparam int unsigned ResCntW  = $clog2(MaxRes + 1);

  localparam logic [7:0] ChOne     = 8'h31;  // '1'
  localparam logic [7:0] ChTwo     = 8'h32;  // '2'
  localparam logic [7:0] ChGt      = 8'h3E;  // '>'
  localparam logic [7:0] ChLt      = 8'h3C;  // '<'
  localparam logic [7:0] ChBslash  = 8'h5C;  // backslash
  localparam logic [7:0] ChSquote  = 8'h27;  // single quote
  localparam logic [7:0] ChDquote  = 8'h22;  // double quote
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0D;

  localparam logic KindChar = 1'b0;
  localparam logic KindEnd  = 1'b1;

  typedef enum logic [2:0] {
    QM_NONE   = 3'b001,
    QM_SINGLE = 3'b010,
    QM_DOUBLE = 3'b100
  } quote_t;

  typedef enum logic [2:0] {
    PEND_NONE  = 3'b001,
    PEND_DIGIT = 3'b010,
    PEND_OP    = 3'b100
  } pend_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    logic       op;
  } res_t;

  // All results caused by one input item.
  typedef struct packed {
    logic [ResCntW-1:0]     cnt;
    res_t [MaxRes-1:0]      ent;
  } res_list_t;

  // Append one result; extra results beyond the list size are dropped.
  function automatic res_list_t push(res_list_t l, logic kind, logic [7:0] ch, logic op);
    res_list_t r;
    r = l;
    if (l.cnt < ResCntW'(MaxRes)) begin
      r.ent[l.cnt[ResIdxW-1:0]].kind = kind;
      r.ent[l.cnt[ResIdxW-1:0]].ch   = ch;
      r.ent[l.cnt[ResIdxW-1:0]].op   = op;
      r.cnt = l.cnt + ResCntW'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/stk_front.sv -----
// ----------------------------------------------------------------------------
// stk_front
// Classifies each command byte against the scanner state and forms the
// list of results it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module stk_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic [7:0]            in_char,
  input  wire logic                  in_last,
  input  wire logic                  q_ready,
  output logic                       push_valid,
  output stk_pkg::res_list_t         push_list
);
  import stk_pkg::*;

  quote_t     quote_r, quote_nxt;
  logic       esc_r, esc_nxt;
  pend_t      pend_r, pend_nxt;
  logic [7:0] digit_r, digit_nxt;
  logic       open_r, open_nxt;
  logic       opop_r, opop_nxt;
  res_list_t  list;
  logic       accept;

  assign accept = in_valid && q_ready;

  always_comb begin
    logic done;
    logic c_quoted;
    done      = 1'b0;
    quote_nxt = quote_r;
    esc_nxt   = esc_r;
    pend_nxt  = pend_r;
    digit_nxt = digit_r;
    open_nxt  = open_r;
    opop_nxt  = opop_r;
    list      = '0;

    // Settle held lookahead against the raw byte.
    case (pend_r)
      PEND_DIGIT: begin
        pend_nxt = PEND_NONE;
        if (in_char == ChGt || in_char == ChLt) begin
          if (open_nxt) begin
            list = push(list, KindEnd, 8'h00, opop_nxt);
          end
          list     = push(list, KindChar, digit_r, 1'b1);
          list     = push(list, KindChar, in_char, 1'b1);
          open_nxt = 1'b1;
          opop_nxt = 1'b1;
          pend_nxt = PEND_OP;
          done     = 1'b1;
        end else begin
          list     = push(list, KindChar, digit_r, 1'b0);
          open_nxt = 1'b1;
          opop_nxt = 1'b0;
        end
      end
      PEND_OP: begin
        pend_nxt = PEND_NONE;
        if (in_char == ChGt) begin
          list = push(list, KindChar, in_char, 1'b1);
          list = push(list, KindEnd, 8'h00, 1'b1);
          done = 1'b1;
        end else if (open_nxt) begin
          list = push(list, KindEnd, 8'h00, opop_nxt);
        end
        if (in_char == ChGt || open_nxt) begin
          open_nxt = 1'b0;
          opop_nxt = 1'b0;
        end
      end
      default: pend_nxt = PEND_NONE;
    endcase

    c_quoted = (quote_r != QM_NONE);

    if (!done) begin
      if (esc_r) begin
        esc_nxt  = 1'b0;
        list     = push(list, KindChar, in_char, 1'b0);
        open_nxt = 1'b1;
        opop_nxt = 1'b0;
      end else if (in_char == ChBslash) begin
        esc_nxt = 1'b1;
      end else if (in_char == ChSquote && quote_r != QM_DOUBLE) begin
        quote_nxt = (quote_r == QM_SINGLE) ? QM_NONE : QM_SINGLE;
      end else if (in_char == ChDquote && quote_r != QM_SINGLE) begin
        quote_nxt = (quote_r == QM_DOUBLE) ? QM_NONE : QM_DOUBLE;
      end else if (!c_quoted) begin
        if (in_char inside {[ChTab:ChCr], ChSpace}) begin
          if (open_nxt) begin
            list = push(list, KindEnd, 8'h00, opop_nxt);
          end
          open_nxt = 1'b0;
          opop_nxt = 1'b0;
        end else if (in_char == ChGt || in_char == ChLt) begin
          if (open_nxt) begin
            list = push(list, KindEnd, 8'h00, opop_nxt);
          end
          list     = push(list, KindChar, in_char, 1'b1);
          open_nxt = 1'b1;
          opop_nxt = 1'b1;
          pend_nxt = PEND_OP;
        end else if (in_char == ChOne || in_char == ChTwo) begin
          pend_nxt  = PEND_DIGIT;
          digit_nxt = in_char;
        end else begin
          list     = push(list, KindChar, in_char, 1'b0);
          open_nxt = 1'b1;
          opop_nxt = 1'b0;
        end
      end else begin
        list     = push(list, KindChar, in_char, 1'b0);
        open_nxt = 1'b1;
        opop_nxt = 1'b0;
      end
    end

    // End of command: flush a held digit, close the token, reset.
    if (in_last) begin
      if (pend_nxt == PEND_DIGIT) begin
        list     = push(list, KindChar, digit_nxt, 1'b0);
        open_nxt = 1'b1;
        opop_nxt = 1'b0;
      end
      if (open_nxt) begin
        list = push(list, KindEnd, 8'h00, opop_nxt);
      end
      quote_nxt = QM_NONE;
      esc_nxt   = 1'b0;
      pend_nxt  = PEND_NONE;
      digit_nxt = 8'h00;
      open_nxt  = 1'b0;
      opop_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_r <= QM_NONE;
      esc_r   <= 1'b0;
      pend_r  <= PEND_NONE;
      digit_r <= 8'h00;
      open_r  <= 1'b0;
      opop_r  <= 1'b0;
    end else if (accept) begin
      quote_r <= quote_nxt;
      esc_r   <= esc_nxt;
      pend_r  <= pend_nxt;
      digit_r <= digit_nxt;
      open_r  <= open_nxt;
      opop_r  <= opop_nxt;
    end
  end

  // Drop items that cause no result.
  assign push_valid = accept && (list.cnt != '0);
  assign push_list  = list;

endmodule

`default_nettype wire

// ----- design/stk_queue.sv -----
// ----------------------------------------------------------------------------
// stk_queue
// Two-entry queue of result lists between the classifier and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module stk_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push_valid,
  input  wire stk_pkg::res_list_t    push_list,
  output logic                       q_ready,
  output logic                       q_valid,
  output stk_pkg::res_list_t         q_head,
  input  wire logic                  pop
);
  import stk_pkg::*;

  res_list_t  mem [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign q_ready = (cnt_r != 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = mem[rptr_r];
  assign do_push = push_valid && q_ready;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wptr_nxt = do_push ? ~wptr_r : wptr_r;
    rptr_nxt = do_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= push_list;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/stk_back.sv -----
// ----------------------------------------------------------------------------
// stk_back
// Emits the queued result lists one result per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module stk_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  input  wire stk_pkg::res_list_t    q_head,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_kind,
  output logic [7:0]                 out_char,
  output logic                       out_op,
  output logic                       out_last
);
  import stk_pkg::*;

  logic [ResIdxW-1:0]  idx_r, idx_nxt;
  logic [ResCntW-1:0]  last_pos;
  logic                fire;

  assign last_pos  = q_head.cnt - ResCntW'(1);
  assign out_valid = q_valid;
  assign out_kind  = q_head.ent[idx_r].kind;
  assign out_char  = q_head.ent[idx_r].ch;
  assign out_op    = q_head.ent[idx_r].op;
  assign out_last  = (idx_r == last_pos[ResIdxW-1:0]);
  assign fire      = out_valid && out_ready;
  assign pop       = fire && out_last;

  always_comb begin
    idx_nxt = idx_r;
    if (fire) begin
      idx_nxt = out_last ? '0 : idx_r + ResIdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/shell_token_scanner.sv -----
// A result appears in the cycle after its byte is accepted, when the queue was empty.
// Throughput: 1 byte per cycle at the input while the queue has room; the output drains
//   1 result per cycle while out_tready is high, so a byte causing k results takes k handshakes (k = 0..4).
// A two-entry queue of result lists lets the input run ahead of output stalls.
// Reset (rst_n low, synchronous): scanner state returns to unquoted with nothing
//   pending, and the queue and the output position empty.
// ----------------------------------------------------------------------------
// shell_token_scanner
// Streaming tokenizer for one shell command: bytes in, token characters and
// token-end markers out, with quoting, escapes and redirection operators.
// ----------------------------------------------------------------------------
`default_nettype none

module shell_token_scanner (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_value
  input  wire logic        in_tlast,   // end_of_command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] token_char, [8] is_operator, zero above
  output logic             out_tuser,  // kind: 0 character, 1 end of token
  output logic             out_tlast   // last_of_run
);
  import stk_pkg::*;

  logic      push_valid;
  res_list_t push_list;
  logic      q_ready;
  logic      q_valid;
  res_list_t q_head;
  logic      pop;
  logic [7:0] tok_char;
  logic      tok_op;

  // Front: hold scanner state, classify each byte, build its result list.
  stk_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_char    (in_tdata),
    .in_last    (in_tlast),
    .q_ready    (q_ready),
    .push_valid (push_valid),
    .push_list  (push_list)
  );

  // Accept a byte whenever the queue has room; bytes without results
  // advance the state only.
  assign in_tready = q_ready;

  stk_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_list  (push_list),
    .q_ready    (q_ready),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .pop        (pop)
  );

  // Back: step through the head list, one result per output handshake.
  stk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_char  (tok_char),
    .out_op    (tok_op),
    .out_last  (out_tlast)
  );

  assign out_tdata = {7'b0, tok_op, tok_char};

endmodule

`default_nettype wire
